// ===== hdl/imc_pkg.sv =====
// ----------------------------------------------------------------------------
// imc_pkg
// Shared types and constants for the image mask correlation block.
// ----------------------------------------------------------------------------
package imc_pkg;

    // Fixed sizes of the block.
    localparam int MAX_MASK    = 7;
    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int RING_LINES  = 2 * MAX_MASK;

    // Item action codes.
    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_PIXEL  = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MASK_ROWS  = 3'd0;
    localparam logic [2:0] CFG_MASK_COLS  = 3'd1;
    localparam logic [2:0] CFG_IMAGE_ROWS = 3'd2;
    localparam logic [2:0] CFG_IMAGE_COLS = 3'd3;
    localparam logic [2:0] CFG_NORMALIZE  = 3'd4;

    // Result limits.
    localparam logic signed [32:0] RES_MAX = 33'sd2097151;
    localparam logic signed [32:0] RES_MIN = -33'sd2097152;

    // Clamped configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0]  mr;
        logic [2:0]  mc;
        logic [10:0] img_r;
        logic [10:0] img_c;
        logic        norm;
    } cfg_t;

    // Commands from the controller.
    typedef struct packed {
        logic accept;
        logic clear_cnt;
        logic advance_in;
        logic win_clr;
        logic win_step;
        logic div_start;
        logic emit;
    } cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic in_ge;
        logic out_ge;
        logic in_gt_lag;
        logic tap_last;
        logic pipe_busy;
        logic div_busy;
        logic out_block;
    } stat_t;

endpackage

// ===== hdl/imc_ctrl.sv =====
// ----------------------------------------------------------------------------
// imc_ctrl
// Sequencer: accepts items and steps the datapath through index update,
// window accumulation, division and result hand-off.
// ----------------------------------------------------------------------------
module imc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        action,
    output logic              in_stall,
    output imc_pkg::cmd_t     cmd,
    input  imc_pkg::stat_t    stat
);
    import imc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_IDX   = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_WIN   = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] act_reg, act_next;
    logic       adv_reg, adv_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        adv_next   = adv_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    act_next   = action;
                    adv_next   = 1'b0;
                    if (action == ACT_PIXEL || action == ACT_FLUSH)
                    begin
                        state_next = S_IDX;
                    end
                end
            end
            S_IDX:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (adv_reg)
                begin
                    if ((stat.in_ge || stat.in_gt_lag) && !stat.out_ge)
                    begin
                        cmd.win_clr = 1'b1;
                        state_next  = S_WIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (stat.in_ge && stat.out_ge)
                begin
                    cmd.clear_cnt = 1'b1;
                    state_next    = S_IDX;
                end
                else if (act_reg == ACT_PIXEL && !stat.in_ge)
                begin
                    cmd.advance_in = 1'b1;
                    adv_next       = 1'b1;
                    state_next     = S_IDX;
                end
                else if (stat.in_ge && !stat.out_ge)
                begin
                    cmd.win_clr = 1'b1;
                    state_next  = S_WIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WIN:
            begin
                cmd.win_step = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_block)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_WEIGHT;
            adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            adv_reg   <= adv_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The divider is only started once every window tap has been summed.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.pipe_busy)
    else $error("divider started with taps in flight");

    // A result is only handed off when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !stat.out_block && !stat.div_busy)
    else $error("result issued while output blocked or divider busy");

    // The input counters only advance while the frame still needs pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance_in |-> !stat.in_ge && $past(state_reg == S_IDX))
    else $error("input advanced past the frame");
`endif

endmodule

// ===== hdl/imc_dp.sv =====
// ----------------------------------------------------------------------------
// imc_dp
// Datapath: weight and line memories, frame counters, the window
// multiply-accumulate pipeline, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module imc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  imc_pkg::cfg_t        cfg,
    input  imc_pkg::cmd_t        cmd,
    output imc_pkg::stat_t       stat,
    input  logic [1:0]           action,
    input  logic [5:0]           weight_index,
    input  logic signed [15:0]   weight_value,
    input  logic [7:0]           pixel_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [21:0]   result_value,
    output logic [9:0]           result_row,
    output logic [9:0]           result_col,
    output logic                 frame_end,
    output logic                 zero_weight_sum
);
    import imc_pkg::*;

    // Memories.
    logic signed [15:0] wmem [MAX_MASK*MAX_MASK];
    logic [7:0]         lmem [RING_LINES*MAX_WIDTH];

    logic [7:0]  pix_reg;

    // Frame counters.
    logic [10:0] in_row_reg, in_row_next;
    logic [9:0]  in_col_reg, in_col_next;
    logic [3:0]  in_line_reg, in_line_next;
    logic [10:0] out_row_reg, out_row_next;
    logic [9:0]  out_col_reg, out_col_next;
    logic [3:0]  out_line_reg, out_line_next;

    // Frame positions.
    logic [21:0] in_idx_reg, out_idx_reg, total_reg, lag_reg;
    logic [2:0]  down, dcol, up, left;

    // Window walk and pipeline.
    logic [2:0]         x_reg, y_reg;
    logic signed [11:0] kk, ll;
    logic signed [5:0]  ln;
    logic [3:0]         lidx;
    logic               tap_ok;
    logic [5:0]         waddr;
    logic [13:0]        laddr;
    logic               s1_reg, v1_reg, s2_reg, v2_reg;
    logic signed [15:0] wr_reg, w2_reg;
    logic [7:0]         pr_reg;
    logic signed [24:0] prod_mul, prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [21:0] wsum_reg;

    // Divider.
    logic        div_busy_reg, used_div_reg, neg_reg;
    logic [31:0] dq_reg;
    logic [21:0] dd_reg;
    logic [22:0] rem_reg, rem_sh;
    logic [5:0]  cnt_reg;

    // Result forming.
    logic signed [31:0] acc_div256;
    logic signed [32:0] res_wide;
    logic signed [21:0] res_sat;
    logic               out_valid_reg;
    logic [10:0]        col_inc;
    logic [10:0]        ocol_inc;

    assign up   = cfg.mr >> 1;
    assign left = cfg.mc >> 1;
    assign down = (cfg.mr - 3'd1) >> 1;
    assign dcol = (cfg.mc - 3'd1) >> 1;

    // Weight memory: written on weight items, read one tap a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && action == ACT_WEIGHT &&
            weight_index < 6'(MAX_MASK*MAX_MASK))
        begin
            wmem[weight_index] <= weight_value;
        end
        wr_reg <= wmem[waddr];
    end

    // Line memory: a ring of image lines, one pixel written per pixel item.
    always_ff @(posedge clk)
    begin
        if (cmd.advance_in)
        begin
            lmem[{in_line_reg, in_col_reg}] <= pix_reg;
        end
        pr_reg <= lmem[laddr];
    end

    // Payload latch for the accepted pixel.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= pixel_value;
        end
    end

    // Frame positions as flat indexes, refreshed every cycle.
    always_ff @(posedge clk)
    begin
        in_idx_reg  <= 22'(in_row_reg) * 22'(cfg.img_c) + 22'(in_col_reg);
        out_idx_reg <= 22'(out_row_reg) * 22'(cfg.img_c) + 22'(out_col_reg);
        total_reg   <= 22'(cfg.img_r) * 22'(cfg.img_c);
        lag_reg     <= 22'(down) * 22'(cfg.img_c) + 22'(dcol);
    end

    // Counter updates.
    assign col_inc  = 11'(in_col_reg) + 11'd1;
    assign ocol_inc = 11'(out_col_reg) + 11'd1;

    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_line_next  = in_line_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_line_next = out_line_reg;
        if (cmd.clear_cnt)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_line_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_line_next = '0;
        end
        if (cmd.advance_in)
        begin
            if (col_inc >= cfg.img_c)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + 11'd1;
                in_line_next = (in_line_reg == 4'(RING_LINES - 1)) ? 4'd0
                                                                  : in_line_reg + 4'd1;
            end
            else
            begin
                in_col_next = col_inc[9:0];
            end
        end
        if (cmd.emit)
        begin
            if (ocol_inc >= cfg.img_c)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 11'd1;
                out_line_next = (out_line_reg == 4'(RING_LINES - 1)) ? 4'd0
                                                                    : out_line_reg + 4'd1;
            end
            else
            begin
                out_col_next = ocol_inc[9:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_line_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_line_reg <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_line_reg  <= in_line_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_line_reg <= out_line_next;
        end
    end

    // Current tap position and its bounds check.
    always_comb
    begin
        kk = $signed(12'(out_row_reg)) - $signed(12'(up)) + $signed(12'(x_reg));
        ll = $signed(12'(out_col_reg)) - $signed(12'(left)) + $signed(12'(y_reg));
        ln = $signed(6'(out_line_reg)) - $signed(6'(up)) + $signed(6'(x_reg));
        if (ln < 0)
        begin
            lidx = 4'(ln + 6'sd14);
        end
        else if (ln >= 6'(RING_LINES))
        begin
            lidx = 4'(ln - 6'sd14);
        end
        else
        begin
            lidx = ln[3:0];
        end
        tap_ok = !kk[11] && (kk[10:0] < cfg.img_r) && !ll[11] && (ll[10:0] < cfg.img_c);
        waddr  = 6'({3'b0, x_reg} * 6'(MAX_MASK)) + 6'(y_reg);
        laddr  = {lidx, ll[9:0]};
    end

    assign prod_mul = $signed(wr_reg) * $signed({1'b0, pr_reg});

    // Window walk and multiply-accumulate pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= cmd.win_step;
            s2_reg <= s1_reg;
            if (cmd.win_clr)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (cmd.win_step)
            begin
                if (y_reg == cfg.mc - 3'd1)
                begin
                    y_reg <= '0;
                    x_reg <= x_reg + 3'd1;
                end
                else
                begin
                    y_reg <= y_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg   <= tap_ok;
        v2_reg   <= v1_reg;
        prod_reg <= prod_mul;
        w2_reg   <= wr_reg;
        if (cmd.win_clr)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (s2_reg && v2_reg)
        begin
            acc_reg  <= acc_reg + 32'(prod_reg);
            wsum_reg <= wsum_reg + 22'(w2_reg);
        end
    end

    // Restoring divider on magnitudes, one quotient bit a cycle.
    assign rem_sh = {rem_reg[21:0], dq_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= cfg.norm && (wsum_reg != 0);
        end
        else if (div_busy_reg && cnt_reg == 6'd1)
        begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            used_div_reg <= cfg.norm && (wsum_reg != 0);
            neg_reg      <= acc_reg[31] ^ wsum_reg[21];
            dq_reg       <= acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
            dd_reg       <= wsum_reg[21] ? 22'(-wsum_reg) : 22'(wsum_reg);
            rem_reg      <= '0;
            cnt_reg      <= 6'd32;
        end
        else if (div_busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (rem_sh >= 23'(dd_reg))
            begin
                rem_reg <= rem_sh - 23'(dd_reg);
                dq_reg  <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dq_reg  <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    // Result: truncate toward zero, then saturate.
    always_comb
    begin
        acc_div256 = acc_reg[31] ? ((acc_reg + 32'sd255) >>> 8) : (acc_reg >>> 8);
        if (used_div_reg)
        begin
            res_wide = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
        end
        else
        begin
            res_wide = 33'(acc_div256);
        end
        if (res_wide > RES_MAX)
        begin
            res_sat = 22'(RES_MAX);
        end
        else if (res_wide < RES_MIN)
        begin
            res_sat = 22'(RES_MIN);
        end
        else
        begin
            res_sat = res_wide[21:0];
        end
    end

    // Output register: holds one result beat until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_value    <= res_sat;
            result_row      <= out_row_reg[9:0];
            result_col      <= out_col_reg;
            frame_end       <= (out_idx_reg + 22'd1 == total_reg);
            zero_weight_sum <= cfg.norm && (wsum_reg == 0);
        end
    end

    assign out_valid = out_valid_reg;

    // Status to the controller.
    always_comb
    begin
        stat.in_ge     = in_idx_reg >= total_reg;
        stat.out_ge    = out_idx_reg >= total_reg;
        stat.in_gt_lag = 23'(in_idx_reg) > 23'(out_idx_reg) + 23'(lag_reg);
        stat.tap_last  = (x_reg == cfg.mr - 3'd1) && (y_reg == cfg.mc - 3'd1);
        stat.pipe_busy = s1_reg || s2_reg;
        stat.div_busy  = div_busy_reg;
        stat.out_block = out_valid_reg && out_stall;
    end

`ifndef NO_ASSERTIONS
    // The window walk never runs while a division is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_step |-> !div_busy_reg)
    else $error("window step during division");

    // A new result never overwrites one that is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
    else $error("result register overwritten");

    // The divider finishes only once its bit counter has run down to one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(div_busy_reg) |-> $past(cnt_reg == 6'd1))
    else $error("divider stopped early");
`endif

endmodule

// ===== hdl/image_mask_correlation.sv =====
// ----------------------------------------------------------------------------
// image_mask_correlation
// Windowed weighted sum of a mask over a raster-streamed grey image.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one beat per item. Action 0 loads a mask
// weight, 1 brings a pixel in raster order, 2 is a flush tick that drains
// pending results once the whole image has arrived.
// Output channel (out_valid/out_stall): one beat per filtered pixel, with its
// row, column, last-pixel flag and zero-weight-sum flag.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 mask rows, 1 mask columns, 2 image rows, 3 image columns, 4 normalize).
// Sequence: a weight item or an unknown action is taken while the block is
// idle and needs no further steps. A pixel or flush item passes index update
// and decision; one that follows a finished frame first clears the counters.
// One that gives a result then walks the window, the taps passing one per
// cycle through the single multiply-accumulate unit, waits for the pipeline
// to drain and, when the divider runs, forms the quotient one bit per cycle.
// Items are handled one at a time.
// Reset clears the counters, the configuration (3x3 mask, 256x256 image,
// no normalization) and the output register; weights must be loaded again.
// While the receiver stalls, the held result stays and the next result waits.
// ----------------------------------------------------------------------------
module image_mask_correlation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [5:0]          weight_index,
    input  logic signed [15:0]  weight_value,
    input  logic [7:0]          pixel_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [21:0]  result_value,
    output logic [9:0]          result_row,
    output logic [9:0]          result_col,
    output logic                frame_end,
    output logic                zero_weight_sum,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [10:0]         cfg_data
);
    import imc_pkg::*;

    logic [2:0]  mask_rows_reg, mask_cols_reg;
    logic [10:0] image_rows_reg, image_cols_reg;
    logic        normalize_reg;
    cfg_t        cfg;
    cmd_t        cmd;
    stat_t       stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_rows_reg  <= 3'd3;
            mask_cols_reg  <= 3'd3;
            image_rows_reg <= 11'd256;
            image_cols_reg <= 11'd256;
            normalize_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MASK_ROWS:  mask_rows_reg  <= cfg_data[2:0];
                CFG_MASK_COLS:  mask_cols_reg  <= cfg_data[2:0];
                CFG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                CFG_IMAGE_COLS: image_cols_reg <= cfg_data;
                CFG_NORMALIZE:  normalize_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Clamp the configuration to its working range.
    always_comb
    begin
        cfg.mr    = (mask_rows_reg == 3'd0) ? 3'd1 : mask_rows_reg;
        cfg.mc    = (mask_cols_reg == 3'd0) ? 3'd1 : mask_cols_reg;
        cfg.img_r = (image_rows_reg == 11'd0) ? 11'd1 :
                    (image_rows_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_rows_reg;
        cfg.img_c = (image_cols_reg == 11'd0) ? 11'd1 :
                    (image_cols_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_cols_reg;
        cfg.norm  = normalize_reg;
    end

    imc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    imc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .action          (action),
        .weight_index    (weight_index),
        .weight_value    (weight_value),
        .pixel_value     (pixel_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_value    (result_value),
        .result_row      (result_row),
        .result_col      (result_col),
        .frame_end       (frame_end),
        .zero_weight_sum (zero_weight_sum)
    );

endmodule
